// ----- rtl/oaids_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oaids_pkg
// shared constants and types for the ordered array insert/delete/search block
// ----------------------------------------------------------------------------
package oaids_pkg;

    // storage geometry
    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;

    // field widths
    localparam int FUNC_W = 2;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 7;
    localparam int CNT_W  = 8;

    // priority search split into groups of cells
    localparam int GRP     = 16;
    localparam int NGRP    = DEPTH / GRP;
    localparam int GIDX_W  = $clog2(GRP);
    localparam int GSEL_W  = $clog2(NGRP);

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_PICK
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic ins;       // insert in progress
        logic del;       // delete in progress
        logic cmp;       // search compare
        logic at_pos;    // cell index equals pos
        logic after_pos; // cell index above pos
        logic valid;     // cell index below count
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- rtl/oaids_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oaids_cell
// one array entry: holds a value, shifts with its neighbors, compares
// ----------------------------------------------------------------------------
module oaids_cell (
    input  wire                                           i_clk,
    input  wire  oaids_pkg::t_cell_ctl                    i_ctl,
    input  wire  logic signed [oaids_pkg::DATA_WIDTH-1:0] i_value,
    input  wire  logic signed [oaids_pkg::DATA_WIDTH-1:0] i_left,
    input  wire  logic signed [oaids_pkg::DATA_WIDTH-1:0] i_right,
    output logic signed [oaids_pkg::DATA_WIDTH-1:0]       o_data,
    output logic                                          o_match
);
    import oaids_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_data;
    logic signed [DATA_WIDTH-1:0] n_data;
    logic                         r_match;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins && i_ctl.at_pos) begin
            n_data = i_value;
        end else if (i_ctl.ins && i_ctl.after_pos) begin
            n_data = i_left;
        end else if (i_ctl.del && (i_ctl.at_pos || i_ctl.after_pos)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_match <= i_ctl.cmp && i_ctl.valid && (r_data == i_value);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule
`default_nettype wire

// ----- rtl/oaids_grp_enc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// oaids_grp_enc
// registered lowest-index priority encoder over one group of match bits
// ----------------------------------------------------------------------------
module oaids_grp_enc (
    input  wire                             i_clk,
    input  wire                             i_en,
    input  wire  [oaids_pkg::GRP-1:0]       i_match,
    output logic                            o_hit,
    output logic [oaids_pkg::GIDX_W-1:0]    o_idx
);
    import oaids_pkg::*;

    logic              r_hit;
    logic [GIDX_W-1:0] r_idx;
    logic [GIDX_W-1:0] c_idx;

    // scan from the top so the lowest set bit wins
    always_comb begin
        c_idx = '0;
        for (int k = GRP - 1; k >= 0; k--) begin
            if (i_match[k]) begin
                c_idx = GIDX_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= |i_match;
            r_idx <= c_idx;
        end
    end

    assign o_hit = r_hit;
    assign o_idx = r_idx;

endmodule
`default_nettype wire

// ----- rtl/ordered_array_insert_delete_search.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search
// packed array of signed values with positional insert, delete and search
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// command   in         start high, busy low      i_func, i_pos, i_value
// result    out        o_done strobe, one cycle  o_status, o_found_index,
//                                                o_entry_count
//
// insert, delete and unused codes: the result strobe is registered at the
//   same edge that updates the cell row
// search: passes through the cell compare stage and the two-level registered
//   priority encoder (groups, then group select)
// busy is high from the accepting edge until the result is registered, so a
//   new command may be taken in the same cycle the previous strobe shows
// synchronous active-low reset clears the count and the sequencer; the
//   array contents are left as they are and only entries below the count
//   are ever read
// the receiver cannot stall: every strobe is a finished transaction
//
module ordered_array_insert_delete_search (
    input  wire                                           i_clk,
    input  wire                                           i_rst_n,
    input  wire                                           start,
    output logic                                          busy,
    input  wire  [oaids_pkg::FUNC_W-1:0]                  i_func,
    input  wire  [oaids_pkg::POS_W-1:0]                   i_pos,
    input  wire  logic signed [oaids_pkg::DATA_WIDTH-1:0] i_value,
    output logic                                          o_done,
    output logic [oaids_pkg::STAT_W-1:0]                  o_status,
    output logic [oaids_pkg::IDX_W-1:0]                   o_found_index,
    output logic [oaids_pkg::CNT_W-1:0]                   o_entry_count
);
    import oaids_pkg::*;

    // sequencer
    t_state r_state;
    t_state n_state;

    // latched command
    logic [FUNC_W-1:0]            r_func;
    logic [POS_W-1:0]             r_pos;
    logic signed [DATA_WIDTH-1:0] r_value;

    // entries in use
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // registered result
    logic              r_done;
    logic [STAT_W-1:0] r_status;
    logic [IDX_W-1:0]  r_found;
    logic [CNT_W-1:0]  r_cnt_out;

    // sequencer outputs
    logic              c_ins;
    logic              c_del;
    logic              c_cmp;
    logic              c_scan;
    logic              c_res_valid;
    logic [STAT_W-1:0] c_status;
    logic [IDX_W-1:0]  c_found;
    logic              c_hit;
    logic [IDX_W-1:0]  c_pick_idx;

    logic accept;

    // cell row
    t_cell_ctl                    cell_ctl  [DEPTH];
    logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]             cell_match;

    // group encoder outputs
    logic [NGRP-1:0]   grp_hit;
    logic [GIDX_W-1:0] grp_idx [NGRP];

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // command register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_pos   <= i_pos;
            r_value <= i_value;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (r_func == FN_SEARCH) ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // final pick over the group results, lowest group wins
    always_comb begin
        c_hit      = |grp_hit;
        c_pick_idx = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_hit[g]) begin
                c_pick_idx = {GSEL_W'(g), grp_idx[g]};
            end
        end
    end

    // sequencer outputs
    always_comb begin
        c_ins       = 1'b0;
        c_del       = 1'b0;
        c_cmp       = 1'b0;
        c_scan      = 1'b0;
        c_res_valid = 1'b0;
        c_status    = ST_OK;
        c_found     = '0;
        n_count     = r_count;
        case (r_state)
            S_EXEC: begin
                c_res_valid = (r_func != FN_SEARCH);
                case (r_func)
                    FN_INSERT: begin
                        // full check takes priority over the position check
                        if (r_count == CNT_W'(DEPTH)) begin
                            c_status = ST_FULL;
                        end else if (r_pos > r_count) begin
                            c_status = ST_BADPOS;
                        end else begin
                            c_ins   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    FN_DELETE: begin
                        if (r_pos < r_count) begin
                            c_del   = 1'b1;
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            c_status = ST_BADPOS;
                        end
                    end
                    FN_SEARCH: begin
                        c_cmp = 1'b1;
                    end
                    default: begin
                        // unused code: no change, ok status
                        c_status = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                c_scan = 1'b1;
            end
            S_PICK: begin
                c_res_valid = 1'b1;
                if (c_hit) begin
                    c_status = ST_OK;
                    c_found  = c_pick_idx;
                end else begin
                    c_status = ST_NOTFOUND;
                end
            end
            default: begin
                c_res_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= c_res_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (c_res_valid) begin
            r_status  <= c_status;
            r_found   <= c_found;
            r_cnt_out <= n_count;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_entry_count = r_cnt_out;

    // cell row: each cell sees its left and right neighbor
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_data;
        logic signed [DATA_WIDTH-1:0] right_data;

        always_comb begin
            cell_ctl[i].ins       = c_ins;
            cell_ctl[i].del       = c_del;
            cell_ctl[i].cmp       = c_cmp;
            cell_ctl[i].at_pos    = (r_pos == POS_W'(i));
            cell_ctl[i].after_pos = (r_pos < POS_W'(i));
            cell_ctl[i].valid     = (CNT_W'(i) < r_count);
        end

        if (i == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        oaids_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[i]),
            .i_value (r_value),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[i]),
            .o_match (cell_match[i])
        );
    end

    // first level of the priority search
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        oaids_grp_enc u_grp (
            .i_clk   (i_clk),
            .i_en    (c_scan),
            .i_match (cell_match[g*GRP +: GRP]),
            .o_hit   (grp_hit[g]),
            .o_idx   (grp_idx[g])
        );
    end

`ifndef SYNTHESIS
    // a strobe only follows an execute step or a search pick
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == S_EXEC || $past(r_state) == S_PICK))
        else $error("result strobe without a finishing step");

    // count stays within the array
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // a successful insert grows the count by one
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count");

    // full status only when the array really is full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_entry_count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    // a search moves on from execute to scan and stays busy, so no new command is taken
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_func == FN_SEARCH) |=> (r_state == S_SCAN && busy))
        else $error("search left the sequencer early");
`endif

endmodule
`default_nettype wire

// ----- dv/oaids_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oaids_checker
// watches the command and result channels, predicts every result from a
// private copy of the array and compares it field by field
// ----------------------------------------------------------------------------
module oaids_checker (
    input  wire                                           i_clk,
    input  wire                                           i_rst_n,
    input  wire                                           i_start,
    input  wire                                           i_busy,
    input  wire  [oaids_pkg::FUNC_W-1:0]                  i_func,
    input  wire  [oaids_pkg::POS_W-1:0]                   i_pos,
    input  wire  logic signed [oaids_pkg::DATA_WIDTH-1:0] i_value,
    input  wire                                           i_done,
    input  wire  [oaids_pkg::STAT_W-1:0]                  i_status,
    input  wire  [oaids_pkg::IDX_W-1:0]                   i_found_index,
    input  wire  [oaids_pkg::CNT_W-1:0]                   i_entry_count,
    output int                                            o_failures,
    output int                                            o_pending,
    output int                                            o_checked
);
    import oaids_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  found_idx;
        logic [CNT_W-1:0]  count;
    } t_array_result;

    // private copy of the array; entries at or above fill are never read
    logic signed [DATA_WIDTH-1:0] shadow_array [DEPTH];
    int                           fill;
    t_array_result                pending_results [$];

    initial begin
        fill       = 0;
        o_failures = 0;
        o_pending  = 0;
        o_checked  = 0;
    end

    // applies one command to the private array and returns what it must report
    function automatic t_array_result predict_array_op(
        input logic [FUNC_W-1:0]            fn,
        input logic [POS_W-1:0]             p,
        input logic signed [DATA_WIDTH-1:0] v
    );
        t_array_result r;
        int            i;
        bit            hit;
        r.status    = ST_OK;
        r.found_idx = '0;
        hit         = 1'b0;
        case (fn)
            FN_INSERT: begin
                // full is checked ahead of the position
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (int'(p) > fill) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (i = fill; i > int'(p); i--)
                        shadow_array[i] = shadow_array[i-1];
                    shadow_array[p] = v;
                    fill++;
                end
            end
            FN_DELETE: begin
                if (int'(p) >= fill) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (i = int'(p); i + 1 < fill; i++)
                        shadow_array[i] = shadow_array[i+1];
                    fill--;
                end
            end
            FN_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < fill; i++) begin
                    if (!hit && shadow_array[i] == v) begin
                        hit         = 1'b1;
                        r.status    = ST_OK;
                        r.found_idx = i[IDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.count = fill[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_array_result seen;
        t_array_result want;
        seen = '{status: i_status, found_idx: i_found_index, count: i_entry_count};
        if (!i_rst_n) begin
            fill = 0;
            pending_results.delete();
        end else begin
            // the result of the previous transaction may share this edge
            // with the next acceptance, so retire it first
            if (i_done) begin
                if (pending_results.size() == 0) begin
                    o_failures++;
                    if (o_failures <= REPORT_LIMIT)
                        $display("%0t: stray result: status %0d index %0d count %0d",
                                 $time, seen.status, seen.found_idx, seen.count);
                end else begin
                    want = pending_results.pop_front();
                    o_checked++;
                    if (seen !== want) begin
                        o_failures++;
                        if (o_failures <= REPORT_LIMIT)
                            $display("%0t: exp %0d %0d %0d got %0d %0d %0d (st idx cnt)",
                                     $time, want.status, want.found_idx, want.count,
                                     seen.status, seen.found_idx, seen.count);
                    end
                end
            end
            if (i_start && !i_busy)
                pending_results.push_back(predict_array_op(i_func, i_pos, i_value));
        end
        o_pending <= pending_results.size();
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// random and directed insert, delete and search traffic for the ordered array
// ----------------------------------------------------------------------------
module testbench;
    import oaids_pkg::*;

    // the package names three operations; the fourth code must be a no-op
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 750;
    localparam int CYCLE_LIMIT   = 400_000;
    // settle time long enough to cover a search, the slowest transaction
    localparam int SETTLE_CYCLES = 8;

    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // traffic phases: fill the array up, drain it down, then mix
    typedef enum {
        PHASE_GROW,
        PHASE_SHRINK,
        PHASE_MIXED
    } t_traffic_phase;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start   = 1'b0;
    logic                          busy;
    logic [FUNC_W-1:0]             i_func  = FN_SEARCH;
    logic [POS_W-1:0]              i_pos   = '0;
    logic signed [DATA_WIDTH-1:0]  i_value = '0;
    logic                          o_done;
    logic [STAT_W-1:0]             o_status;
    logic [IDX_W-1:0]              o_found_index;
    logic [CNT_W-1:0]              o_entry_count;

    int failures;
    int pending;
    int checked;
    int cycle_count = 0;

    // stimulus side bookkeeping: a shadow of the fill level, used only to
    // steer positions toward the interesting places
    int level        = 0;
    int n_insert     = 0;
    int n_delete     = 0;
    int n_search     = 0;
    int n_unused     = 0;
    int full_reached = 0;
    int full_refused = 0;
    int empty_again  = 0;

    // small pool of values so that searches hit and duplicates show up
    logic signed [DATA_WIDTH-1:0] value_pool [8];

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    ordered_array_insert_delete_search i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_pos         (i_pos),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_entry_count (o_entry_count)
    );

    oaids_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_func        (i_func),
        .i_pos         (i_pos),
        .i_value       (i_value),
        .i_done        (o_done),
        .i_status      (o_status),
        .i_found_index (o_found_index),
        .i_entry_count (o_entry_count),
        .o_failures    (failures),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // hard stop if the handshake ever hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results pending",
                     cycle_count, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // one transaction: raise start with the fields and hold them until an
    // edge sees busy low; called right after a rising edge, and returns at
    // the edge that took the command
    task automatic issue_command(
        input logic [FUNC_W-1:0]            fn,
        input logic [POS_W-1:0]             p,
        input logic signed [DATA_WIDTH-1:0] v
    );
        start   <= 1'b1;
        i_func  <= fn;
        i_pos   <= p;
        i_value <= v;
        @(posedge i_clk);
        // busy still shows its pre-edge value here
        while (busy) @(posedge i_clk);
        case (fn)
            FN_INSERT: begin
                n_insert++;
                if (level == DEPTH) begin
                    full_refused++;
                end else if (int'(p) <= level) begin
                    level++;
                    if (level == DEPTH) full_reached++;
                end
            end
            FN_DELETE: begin
                n_delete++;
                if (int'(p) < level) begin
                    level--;
                    if (level == 0) empty_again++;
                end
            end
            FN_SEARCH: n_search++;
            default:   n_unused++;
        endcase
    endtask

    // idle between transactions: mostly back to back, some short gaps,
    // a few long ones; fields are scrambled while start is low
    task automatic random_gap(input bit no_idle);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            n = 0;
        else if (r < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 40);
        if (n > 0) begin
            start   <= 1'b0;
            i_func  <= FUNC_W'($urandom);
            i_pos   <= POS_W'($urandom);
            i_value <= $urandom;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    initial begin
        t_traffic_phase               phase;
        logic [FUNC_W-1:0]            fn;
        logic [POS_W-1:0]             p;
        logic signed [DATA_WIDTH-1:0] v;
        int                           ins_w;
        int                           del_w;
        int                           r;
        int                           n;
        int                           dwell;
        bit                           no_idle;
        bit                           switched;

        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = '0;
        value_pool[3] = '1;
        for (n = 4; n < 8; n++) value_pool[n] = $urandom;

        // synchronous reset before the first command
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // empty array: search misses, every delete and off-end insert is refused
        issue_command(FN_SEARCH, 8'd0, '0);               random_gap(1'b0);
        issue_command(FN_DELETE, 8'd0, '0);               random_gap(1'b0);
        issue_command(FN_INSERT, 8'd1, 32'sd5);           random_gap(1'b0);
        issue_command(FN_INSERT, 8'd255, VAL_MAX);        random_gap(1'b0);
        // build [-1, 0, max, min, max]: front, append, middle, duplicate
        issue_command(FN_INSERT, 8'd0, VAL_MIN);          random_gap(1'b0);
        issue_command(FN_INSERT, 8'd1, VAL_MAX);          random_gap(1'b0);
        issue_command(FN_INSERT, 8'd0, -32'sd1);          random_gap(1'b0);
        issue_command(FN_INSERT, 8'd1, 32'sd0);           random_gap(1'b0);
        issue_command(FN_INSERT, 8'd2, VAL_MAX);          random_gap(1'b0);
        // duplicate value must report the lowest index
        issue_command(FN_SEARCH, 8'd99, VAL_MAX);         random_gap(1'b0);
        issue_command(FN_SEARCH, 8'd0, VAL_MIN);          random_gap(1'b0);
        issue_command(FN_SEARCH, 8'd255, -32'sd1);        random_gap(1'b0);
        issue_command(FN_SEARCH, 8'd0, 32'sd12345);       random_gap(1'b0);
        // unused code leaves everything alone
        issue_command(FN_UNUSED, 8'd3, 32'sd77);          random_gap(1'b0);
        // delete exactly at the count, then last, front and middle
        issue_command(FN_DELETE, 8'd5, '0);               random_gap(1'b0);
        issue_command(FN_DELETE, 8'd4, '0);               random_gap(1'b0);
        issue_command(FN_DELETE, 8'd0, '0);               random_gap(1'b0);
        issue_command(FN_DELETE, 8'd1, '0);               random_gap(1'b0);
        issue_command(FN_SEARCH, 8'd0, VAL_MAX);          random_gap(1'b0);
        issue_command(FN_SEARCH, 8'd0, VAL_MIN);          random_gap(1'b0);
        // positions far past the end
        issue_command(FN_INSERT, 8'd128, 32'sd1);         random_gap(1'b0);
        issue_command(FN_DELETE, 8'd128, '0);             random_gap(1'b0);
        issue_command(FN_UNUSED, 8'd255, '1);             random_gap(1'b0);
        wait_for_drain();

        // ---- random part ----
        // grow until full and sit there a while (full refusals, full-priority
        // over bad position), drain to empty, mix for a while, repeat
        phase   = PHASE_GROW;
        dwell   = 0;
        no_idle = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            switched = 1'b0;
            case (phase)
                PHASE_GROW: if (level == DEPTH && ++dwell > 12) begin
                    phase    = PHASE_SHRINK;
                    switched = 1'b1;
                end
                PHASE_SHRINK: if (level == 0 && ++dwell > 6) begin
                    phase    = PHASE_MIXED;
                    switched = 1'b1;
                end
                default: if (++dwell > 60) begin
                    phase    = PHASE_GROW;
                    switched = 1'b1;
                end
            endcase
            if (switched) begin
                dwell = 0;
                wait_for_drain();
                // some phases run with no idling at all
                no_idle = ($urandom_range(0, 3) == 0);
            end

            case (phase)
                PHASE_GROW:   begin ins_w = 65; del_w = 15; end
                PHASE_SHRINK: begin ins_w = 15; del_w = 65; end
                default:      begin ins_w = 35; del_w = 30; end
            endcase

            r = $urandom_range(0, 99);
            v = pick_value();
            if (r < ins_w) begin
                fn = FN_INSERT;
                case ($urandom_range(0, 3))
                    0:       p = '0;
                    1:       p = POS_W'(level);
                    default: p = POS_W'($urandom_range(0, level));
                endcase
            end else if (r < ins_w + del_w) begin
                fn = FN_DELETE;
                if (level == 0)
                    p = '0;
                else case ($urandom_range(0, 3))
                    0:       p = '0;
                    1:       p = POS_W'(level - 1);
                    default: p = POS_W'($urandom_range(0, level - 1));
                endcase
            end else if (r < 95) begin
                fn = FN_SEARCH;
                p  = POS_W'($urandom);
            end else begin
                // noise: unused code and out-of-range positions
                case ($urandom_range(0, 2))
                    0: begin
                        fn = FN_UNUSED;
                        p  = POS_W'($urandom);
                        v  = $urandom;
                    end
                    1: begin
                        fn = FN_INSERT;
                        p  = POS_W'($urandom_range(level + 1, 255));
                    end
                    default: begin
                        fn = FN_DELETE;
                        p  = POS_W'($urandom_range(level, 255));
                    end
                endcase
            end
            issue_command(fn, p, v);
            random_gap(no_idle);
        end

        // wait out every outstanding result, then watch for strays
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d inserts, %0d deletes, %0d searches, %0d unused codes",
                 n_insert, n_delete, n_search, n_unused);
        $display("%0d results checked; array filled %0d times (%0d inserts refused when full)",
                 checked, full_reached, full_refused);
        $display("array emptied %0d times", empty_again);
        if (failures == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d failures, %0d results never arrived", failures, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- ordered_array_insert_delete_search.f -----
rtl/oaids_pkg.sv
rtl/oaids_cell.sv
rtl/oaids_grp_enc.sv
rtl/ordered_array_insert_delete_search.sv
dv/oaids_checker.sv
dv/testbench.sv
